// ===== hw/rtl/sorted_rect_run_coalescer_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted rectangle run coalescer - assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_RECT_RUN_COALESCER_MACROS_SVH
`define SORTED_RECT_RUN_COALESCER_MACROS_SVH

`ifndef SYNTHESIS
`define SRRC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srrc assertion failed");
`define SRRC_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("srrc forbidden condition seen");
`else
`define SRRC_ASSERT(label, clk, rst_n, prop)
`define SRRC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/srrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted rectangle run coalescer - package
// Shared constants, register codes and configuration type.
// ----------------------------------------------------------------------------
package srrc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int TILE_BITS      = 8;
    localparam int THR_BITS       = 2 * TILE_BITS;
    localparam int QUEUE_DEPTH    = 2;
    // power of two, at least 2
    localparam int OUT_DEPTH      = 4;
    localparam int PADDR_BITS     = 3;
    localparam int PDATA_BITS     = 32;

    localparam logic [TILE_BITS-1:0] TILE_RESET = TILE_BITS'(16);
    localparam logic [THR_BITS-1:0]  THR_RESET  =
        THR_BITS'(int'(TILE_RESET) * int'(TILE_RESET));

    typedef enum logic {
        REG_MERGE_MODE = 1'b0,
        REG_TILE_SIZE  = 1'b1
    } reg_index_t;

    typedef enum logic {
        MODE_DISTANCE = 1'b0,
        MODE_ADJACENT = 1'b1
    } merge_mode_t;

    typedef struct packed {
        merge_mode_t           merge_mode;
        logic [THR_BITS-1:0]   thr;
    } cfg_t;

    // queue entry: corner, size, final flag, adjacency break, dx^2, dy^2
    function automatic int entry_bits(input int coord_bits);
        return 8 * coord_bits + 2;
    endfunction

endpackage

// ===== hw/rtl/srrc_if.sv =====
// ----------------------------------------------------------------------------
// Sorted rectangle run coalescer - channel interfaces
// Valid/ready request channels for input rectangles and merged boxes.
// ----------------------------------------------------------------------------
interface srrc_in_if
    import srrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] rect_left;
    logic [COORD_BITS-1:0] rect_top;
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;
    logic                  final_item;

    modport source (
        output valid, rect_left, rect_top, rect_width, rect_height, final_item,
        input  ready
    );
    modport sink (
        input  valid, rect_left, rect_top, rect_width, rect_height, final_item,
        output ready
    );
endinterface

interface srrc_out_if
    import srrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_left;
    logic [COORD_BITS-1:0] out_top;
    logic [COORD_BITS-1:0] out_width;
    logic [COORD_BITS-1:0] out_height;
    logic                  out_last;

    modport source (
        output valid, out_left, out_top, out_width, out_height, out_last,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_top, out_width, out_height, out_last,
        output ready
    );
endinterface

// ===== hw/rtl/srrc_front.sv =====
// ----------------------------------------------------------------------------
// Sorted rectangle run coalescer - front end
// Accepts rectangles and classifies each against the previous one.
// ----------------------------------------------------------------------------
module srrc_front
    import srrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    srrc_in_if.sink                           rect_in,
    output logic                              q_push,
    input  logic                              q_ready,
    output logic [entry_bits(COORD_BITS)-1:0] q_data
);

    localparam int C = COORD_BITS;

    logic [C-1:0]   prev_left_reg, prev_top_reg, prev_width_reg, prev_height_reg;
    logic [C-1:0]   dx, dy;
    logic [2*C-1:0] dx2, dy2;
    logic [C:0]     new_right, new_bottom, prev_right, prev_bottom;
    logic           adj_ok;
    logic           adj_brk;

    assign rect_in.ready = q_ready;
    assign q_push        = rect_in.valid && q_ready;

    assign dx = (rect_in.rect_left >= prev_left_reg) ? rect_in.rect_left - prev_left_reg
                                                     : prev_left_reg - rect_in.rect_left;
    assign dy = (rect_in.rect_top >= prev_top_reg) ? rect_in.rect_top - prev_top_reg
                                                   : prev_top_reg - rect_in.rect_top;
    assign dx2 = {{C{1'b0}}, dx} * {{C{1'b0}}, dx};
    assign dy2 = {{C{1'b0}}, dy} * {{C{1'b0}}, dy};

    assign new_right   = {1'b0, rect_in.rect_left} + {1'b0, rect_in.rect_width};
    assign new_bottom  = {1'b0, rect_in.rect_top} + {1'b0, rect_in.rect_height};
    assign prev_right  = {1'b0, prev_left_reg} + {1'b0, prev_width_reg};
    assign prev_bottom = {1'b0, prev_top_reg} + {1'b0, prev_height_reg};

    assign adj_ok = ({1'b0, prev_left_reg} <= new_right)
                 && ({1'b0, rect_in.rect_left} <= prev_right)
                 && ({1'b0, prev_top_reg} <= new_bottom)
                 && ({1'b0, rect_in.rect_top} <= prev_bottom)
                 && (prev_width_reg == rect_in.rect_width)
                 && (prev_height_reg == rect_in.rect_height);
    assign adj_brk = !adj_ok;

    assign q_data = {rect_in.rect_left, rect_in.rect_top, rect_in.rect_width,
                     rect_in.rect_height, rect_in.final_item, adj_brk, dx2, dy2};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg   <= '0;
            prev_top_reg    <= '0;
            prev_width_reg  <= '0;
            prev_height_reg <= '0;
        end
        else if (q_push)
        begin
            prev_left_reg   <= rect_in.rect_left;
            prev_top_reg    <= rect_in.rect_top;
            prev_width_reg  <= rect_in.rect_width;
            prev_height_reg <= rect_in.rect_height;
        end
    end

endmodule

// ===== hw/rtl/srrc_queue.sv =====
// ----------------------------------------------------------------------------
// Sorted rectangle run coalescer - classification queue
// Short FIFO between front end and back end.
// ----------------------------------------------------------------------------
module srrc_queue
    import srrc_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data,
    input  logic             pop
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push, do_pop;

    assign push_ready = count_reg != CNT_BITS'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_BITS'(1);
        end
        count_next = count_reg + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/srrc_back.sv =====
// ----------------------------------------------------------------------------
// Sorted rectangle run coalescer - back end
// Decides run breaks, grows the bounding box and buffers merged boxes.
// ----------------------------------------------------------------------------
`include "sorted_rect_run_coalescer_macros.svh"

module srrc_back
    import srrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cfg_t                              cfg,
    input  logic                              q_valid,
    input  logic [entry_bits(COORD_BITS)-1:0] q_data,
    output logic                              q_ready,
    srrc_out_if.source                        rect_out
);

    localparam int C         = COORD_BITS;
    localparam int OUT_BITS  = 4 * C + 1;
    localparam int DSQ_BITS  = 2 * C + 1;
    localparam int OPTR_BITS = $clog2(OUT_DEPTH);
    localparam int OCNT_BITS = $clog2(OUT_DEPTH + 1);

    logic [C-1:0]          e_left, e_top, e_width, e_height;
    logic                  e_fin, e_adj_brk;
    logic [2*C-1:0]        e_dx2, e_dy2;

    logic                  run_active_reg, run_active_next;
    logic [C-1:0]          box_left_reg, box_left_next, box_top_reg, box_top_next;
    logic [C:0]            box_right_reg, box_right_next, box_bottom_reg, box_bottom_next;

    logic [DSQ_BITS-1:0]   dsq;
    logic                  dist_brk, brk_rule, emit_old, opening;
    logic [C:0]            r_new, b_new;
    logic [OUT_BITS-1:0]   old_box, new_box, slot0, slot1;
    logic [1:0]            push_n;
    logic                  pop, rd;

    logic [OUT_BITS-1:0]   out_mem_reg [OUT_DEPTH];
    logic [OPTR_BITS-1:0]  out_wr_ptr_reg, out_wr_ptr_next;
    logic [OPTR_BITS-1:0]  out_rd_ptr_reg, out_rd_ptr_next;
    logic [OCNT_BITS-1:0]  out_count_reg, out_count_next;

    function automatic logic [OUT_BITS-1:0] pack_box(
        input logic [C-1:0] l,
        input logic [C-1:0] t,
        input logic [C:0]   r,
        input logic [C:0]   b,
        input logic         last
    );
        logic [C:0]   dw, dh;
        logic [C-1:0] sw, sh;
        dw = r - {1'b0, l};
        dh = b - {1'b0, t};
        sw = dw[C] ? {C{1'b1}} : dw[C-1:0];
        sh = dh[C] ? {C{1'b1}} : dh[C-1:0];
        return {l, t, sw, sh, last};
    endfunction

    assign {e_left, e_top, e_width, e_height, e_fin, e_adj_brk, e_dx2, e_dy2} = q_data;

    assign dsq      = {1'b0, e_dx2} + {1'b0, e_dy2};
    assign dist_brk = dsq > {{(DSQ_BITS - THR_BITS){1'b0}}, cfg.thr};
    assign brk_rule = (cfg.merge_mode == MODE_ADJACENT) ? e_adj_brk : dist_brk;
    assign emit_old = run_active_reg && brk_rule;
    assign opening  = !run_active_reg || brk_rule;

    assign r_new = {1'b0, e_left} + {1'b0, e_width};
    assign b_new = {1'b0, e_top} + {1'b0, e_height};

    always_comb
    begin
        if (opening)
        begin
            box_left_next   = e_left;
            box_top_next    = e_top;
            box_right_next  = r_new;
            box_bottom_next = b_new;
        end
        else
        begin
            box_left_next   = (e_left < box_left_reg) ? e_left : box_left_reg;
            box_top_next    = (e_top < box_top_reg) ? e_top : box_top_reg;
            box_right_next  = (r_new > box_right_reg) ? r_new : box_right_reg;
            box_bottom_next = (b_new > box_bottom_reg) ? b_new : box_bottom_reg;
        end
        run_active_next = !e_fin;
    end

    assign old_box = pack_box(box_left_reg, box_top_reg, box_right_reg, box_bottom_reg, 1'b0);
    assign new_box = pack_box(box_left_next, box_top_next, box_right_next, box_bottom_next,
                              1'b1);
    assign slot0   = emit_old ? old_box : new_box;
    assign slot1   = new_box;
    assign push_n  = {1'b0, emit_old} + {1'b0, e_fin};

    // two free slots needed: one request may close a run and flush a new one
    assign q_ready = out_count_reg <= OCNT_BITS'(OUT_DEPTH - 2);
    assign pop     = q_valid && q_ready;

    assign rect_out.valid = out_count_reg != '0;
    assign {rect_out.out_left, rect_out.out_top, rect_out.out_width,
            rect_out.out_height, rect_out.out_last} = out_mem_reg[out_rd_ptr_reg];
    assign rd = rect_out.valid && rect_out.ready;

    always_comb
    begin
        out_wr_ptr_next = out_wr_ptr_reg + (pop ? OPTR_BITS'(push_n) : '0);
        out_rd_ptr_next = out_rd_ptr_reg + OPTR_BITS'(rd);
        out_count_next  = out_count_reg + (pop ? OCNT_BITS'(push_n) : '0) - OCNT_BITS'(rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_active_reg <= 1'b0;
            box_left_reg   <= '0;
            box_top_reg    <= '0;
            box_right_reg  <= '0;
            box_bottom_reg <= '0;
            out_wr_ptr_reg <= '0;
            out_rd_ptr_reg <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                run_active_reg <= run_active_next;
                box_left_reg   <= box_left_next;
                box_top_reg    <= box_top_next;
                box_right_reg  <= box_right_next;
                box_bottom_reg <= box_bottom_next;
            end
            out_wr_ptr_reg <= out_wr_ptr_next;
            out_rd_ptr_reg <= out_rd_ptr_next;
            out_count_reg  <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && push_n != 2'd0)
        begin
            out_mem_reg[out_wr_ptr_reg] <= slot0;
        end
        if (pop && push_n == 2'd2)
        begin
            out_mem_reg[out_wr_ptr_reg + OPTR_BITS'(1)] <= slot1;
        end
    end

    `SRRC_ASSERT_NEVER(a_out_overflow, clk, rst_n, out_count_reg > OCNT_BITS'(OUT_DEPTH))
    `SRRC_ASSERT(a_final_closes_run, clk, rst_n, (pop && e_fin) |=> !run_active_reg)
    `SRRC_ASSERT(a_break_final_two, clk, rst_n,
                 (pop && run_active_reg && brk_rule && e_fin) |-> (push_n == 2'd2))

endmodule

// ===== hw/rtl/sorted_rect_run_coalescer.sv =====
// ----------------------------------------------------------------------------
// Sorted rectangle run coalescer - top level
// Merges runs of sorted rectangles into bounding boxes.
// ----------------------------------------------------------------------------
// Usage:
//   rect_in  : valid/ready requests, one rectangle each; final_item ends a list.
//   rect_out : valid/ready requests, one merged box each; out_last on the box
//              closed by the final rectangle.
//   APB port : register 0 merge_mode at 0x0, register 1 tile_size at 0x4.
//              Write only while the block is idle.
// Throughput: one rectangle per cycle, set by the single compare-and-extend
//   step in the back end; a rectangle that both breaks a run and is final
//   yields two boxes; that or a stalled rect_out caps the rate at its drain.
// Path: boxes caused by a rectangle are offered after it is accepted, via the
//   classification queue register, then the output buffer register.
// Reset: no run open, previous rectangle zero, merge_mode 0, tile_size 16.
// Stall: rect_out holds up to four boxes; the back end stops when fewer than
//   two slots are free, the two-entry queue fills, and rect_in.ready drops.
// ----------------------------------------------------------------------------
module sorted_rect_run_coalescer
    import srrc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    srrc_in_if.sink               rect_in,
    srrc_out_if.source            rect_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    localparam int E_BITS = entry_bits(COORD_BITS);

    merge_mode_t          merge_mode_reg, merge_mode_next;
    logic [TILE_BITS-1:0] tile_size_reg, tile_size_next;
    logic [THR_BITS-1:0]  thr_reg, thr_next;
    logic                 cfg_wr;
    reg_index_t           reg_index;
    cfg_t                 cfg;

    logic                 q_push, q_push_ready, q_pop_valid, q_pop;
    logic [E_BITS-1:0]    q_in_data, q_out_data;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        merge_mode_next = merge_mode_reg;
        tile_size_next  = tile_size_reg;
        thr_next        = thr_reg;
        if (cfg_wr)
        begin
            case (reg_index)
                REG_MERGE_MODE:
                begin
                    merge_mode_next = merge_mode_t'(pwdata[0]);
                end
                REG_TILE_SIZE:
                begin
                    tile_size_next = pwdata[TILE_BITS-1:0];
                    thr_next       = {{TILE_BITS{1'b0}}, pwdata[TILE_BITS-1:0]}
                                   * {{TILE_BITS{1'b0}}, pwdata[TILE_BITS-1:0]};
                end
                default:
                begin
                    merge_mode_next = merge_mode_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MERGE_MODE: prdata = {{(PDATA_BITS - 1){1'b0}}, merge_mode_reg};
            REG_TILE_SIZE:  prdata = {{(PDATA_BITS - TILE_BITS){1'b0}}, tile_size_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            merge_mode_reg <= MODE_DISTANCE;
            tile_size_reg  <= TILE_RESET;
            thr_reg        <= THR_RESET;
        end
        else
        begin
            merge_mode_reg <= merge_mode_next;
            tile_size_reg  <= tile_size_next;
            thr_reg        <= thr_next;
        end
    end

    assign cfg = '{merge_mode: merge_mode_reg, thr: thr_reg};

    srrc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rect_in (rect_in),
        .q_push  (q_push),
        .q_ready (q_push_ready),
        .q_data  (q_in_data)
    );

    srrc_queue #(
        .WIDTH (E_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in_data),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_out_data),
        .pop        (q_pop)
    );

    srrc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_pop_valid),
        .q_data   (q_out_data),
        .q_ready  (q_pop),
        .rect_out (rect_out)
    );

endmodule
